/* rtl/hfrb_pkg.sv */
// Shared types, codes and constants for the HID frame to report bridge.
// No dependencies; imported by every module of the block.
package hfrb_pkg;

	// frame op codes
	localparam logic [7:0] OP_KEY_PRESS = 8'd1;
	localparam logic [7:0] OP_KEY_LIFT  = 8'd2;
	localparam logic [7:0] OP_REL_ALL   = 8'd3;
	localparam logic [7:0] OP_POINTER   = 8'd4;

	// link event kind
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_LOST  = 1'b1;

	// minimum and exact frame lengths
	localparam logic [15:0] LEN_MIN   = 16'd4;
	localparam logic [15:0] LEN_REL   = 16'd4;
	localparam logic [15:0] LEN_KEY   = 16'd5;
	localparam logic [15:0] LEN_MOUSE = 16'd10;

	// result action codes
	localparam logic [1:0] ACT_PRESS   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_REL_ALL = 2'd2;
	localparam logic [1:0] ACT_MOUSE   = 2'd3;

	// allowed key usages: 1..0xA4 and 0xE0..0xE7
	localparam logic [7:0] USAGE_END = 8'hA5;
	localparam logic [7:0] MOD_LO    = 8'hE0;
	localparam logic [7:0] MOD_HI    = 8'hE7;

	localparam logic [2:0] BTN_MASK = 3'h7;

	// motion budget
	localparam int MAX_CHUNKS = 64;
	localparam int BUDGET     = (MAX_CHUNKS < 1) ? 1 : ((MAX_CHUNKS > 64) ? 64 : MAX_CHUNKS);
	localparam int CHUNK_LIM  = 127;
	localparam int LIM        = BUDGET * CHUNK_LIM;
	localparam int POS_W      = $clog2(LIM + 1) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEC,
		ST_CHUNK,
		ST_SEND
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ONE,
		RES_MOTION
	} res_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;    // capture input word
		logic dec;    // decode captured frame
		logic chunk;  // load next motion chunk into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		res_kind_t kind;  // decode outcome of captured frame
		logic      last;  // output register holds final word
	} dp_sts_t;

endpackage

/* rtl/hfrb_dp.sv */
// Datapath: input capture, frame checks, held-button state, chunk splitter,
// output register. Depends on hfrb_pkg.
module hfrb_dp import hfrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dp_cmd,
	output dp_sts_t            dp_sts,
	input  logic               cmd,
	input  logic [15:0]        frame_len,
	input  logic [7:0]         op_code,
	input  logic [7:0]         flag_bits,
	input  logic [7:0]         arg_byte,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [7:0]  wheel_in,
	output logic [1:0]         action,
	output logic [7:0]         key_code,
	output logic [2:0]         press_mask,
	output logic [2:0]         release_mask,
	output logic               move_valid,
	output logic signed [7:0]  move_x,
	output logic signed [7:0]  move_y,
	output logic signed [7:0]  move_wheel,
	output logic               clipped,
	output logic               last
);

	function automatic logic signed [POS_W-1:0] clamp_budget(input logic signed [15:0] v);
		logic signed [15:0] lim;
		lim = 16'(LIM);
		if (v > lim)
			return POS_W'(LIM);
		else if (v < -lim)
			return -POS_W'(LIM);
		else
			return v[POS_W-1:0];
	endfunction

	function automatic logic signed [7:0] clamp_chunk(input logic signed [POS_W-1:0] v);
		logic signed [POS_W-1:0] lim;
		lim = POS_W'(CHUNK_LIM);
		if (v > lim)
			return 8'(CHUNK_LIM);
		else if (v < -lim)
			return -8'(CHUNK_LIM);
		else
			return v[7:0];
	endfunction

	// captured word
	logic               cmd_q;
	logic [15:0]        len_q;
	logic [7:0]         op_q;
	logic [7:0]         flag_q;
	logic [7:0]         arg_q;
	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic signed [7:0]  whl_q;

	logic [2:0] held_q;

	// motion residue
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic signed [7:0]       w_q;
	logic [2:0]              prs_q;
	logic [2:0]              rel_q;
	logic                    clip_q;
	logic                    first_q;

	// output register
	logic [1:0]        act_q;
	logic [7:0]        key_q;
	logic [2:0]        pm_q;
	logic [2:0]        rm_q;
	logic              mv_q;
	logic signed [7:0] mx_q;
	logic signed [7:0] my_q;
	logic signed [7:0] mw_q;
	logic              oclip_q;
	logic              last_q;

	// decode
	logic      frame_ok;
	logic      usage_ok;
	logic      is_rel_all;
	logic      is_key;
	logic      is_mouse;
	logic      no_motion;
	logic [2:0] btn;
	logic [2:0] prs;
	logic [2:0] rel;
	res_kind_t kind;

	// chunk step
	logic signed [7:0]       sx;
	logic signed [7:0]       sy;
	logic signed [POS_W-1:0] nx;
	logic signed [POS_W-1:0] ny;

	always_comb begin
		frame_ok   = (len_q >= LEN_MIN) && flag_q[0];
		usage_ok   = ((arg_q >= MOD_LO) && (arg_q <= MOD_HI)) ||
		             ((arg_q != 8'd0) && (arg_q < USAGE_END));
		is_rel_all = (cmd_q == CMD_LOST) ||
		             (frame_ok && (op_q == OP_REL_ALL) && (len_q == LEN_REL));
		is_key     = (cmd_q == CMD_FRAME) && frame_ok &&
		             ((op_q == OP_KEY_PRESS) || (op_q == OP_KEY_LIFT)) &&
		             (len_q == LEN_KEY) && usage_ok;
		is_mouse   = (cmd_q == CMD_FRAME) && frame_ok &&
		             (op_q == OP_POINTER) && (len_q == LEN_MOUSE);
		btn        = arg_q[2:0] & BTN_MASK;
		prs        = btn & ~held_q;
		rel        = held_q & ~btn;
		no_motion  = (dx_q == 16'sd0) && (dy_q == 16'sd0) && (whl_q == 8'sd0);
		if (is_rel_all || is_key)
			kind = RES_ONE;
		else if (is_mouse && no_motion)
			kind = ((prs | rel) != 3'd0) ? RES_ONE : RES_NONE;
		else if (is_mouse)
			kind = RES_MOTION;
		else
			kind = RES_NONE;
	end

	always_comb begin
		sx = clamp_chunk(x_q);
		sy = clamp_chunk(y_q);
		nx = x_q - {{(POS_W-8){sx[7]}}, sx};
		ny = y_q - {{(POS_W-8){sy[7]}}, sy};
	end

	assign dp_sts.kind = kind;
	assign dp_sts.last = last_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.cap) begin
			cmd_q  <= cmd;
			len_q  <= frame_len;
			op_q   <= op_code;
			flag_q <= flag_bits;
			arg_q  <= arg_byte;
			dx_q   <= delta_x;
			dy_q   <= delta_y;
			whl_q  <= wheel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 3'd0;
		end else if (dp_cmd.dec) begin
			if (is_rel_all)
				held_q <= 3'd0;
			else if (is_mouse)
				held_q <= btn;
		end
	end

	// motion setup and chunk splitting
	always_ff @(posedge clk) begin
		if (dp_cmd.dec) begin
			x_q     <= clamp_budget(dx_q);
			y_q     <= clamp_budget(dy_q);
			w_q     <= whl_q;
			prs_q   <= prs;
			rel_q   <= rel;
			clip_q  <= (dx_q > 16'(LIM)) || (dx_q < -16'(LIM)) ||
			           (dy_q > 16'(LIM)) || (dy_q < -16'(LIM));
			first_q <= 1'b1;
		end else if (dp_cmd.chunk) begin
			x_q     <= nx;
			y_q     <= ny;
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.dec) begin
			if (is_rel_all)
				act_q <= ACT_REL_ALL;
			else if (is_key)
				act_q <= (op_q == OP_KEY_PRESS) ? ACT_PRESS : ACT_RELEASE;
			else
				act_q <= ACT_MOUSE;
			key_q   <= is_key ? arg_q : 8'd0;
			pm_q    <= (is_rel_all || is_key) ? 3'd0 : prs;
			rm_q    <= (is_rel_all || is_key) ? 3'd0 : rel;
			mv_q    <= 1'b0;
			mx_q    <= 8'sd0;
			my_q    <= 8'sd0;
			mw_q    <= 8'sd0;
			oclip_q <= 1'b0;
			last_q  <= 1'b1;
		end else if (dp_cmd.chunk) begin
			act_q   <= ACT_MOUSE;
			key_q   <= 8'd0;
			pm_q    <= first_q ? prs_q : 3'd0;
			rm_q    <= first_q ? rel_q : 3'd0;
			mv_q    <= 1'b1;
			mx_q    <= sx;
			my_q    <= sy;
			mw_q    <= first_q ? w_q : 8'sd0;
			oclip_q <= clip_q;
			last_q  <= (nx == '0) && (ny == '0);
		end
	end

	assign action       = act_q;
	assign key_code     = key_q;
	assign press_mask   = pm_q;
	assign release_mask = rm_q;
	assign move_valid   = mv_q;
	assign move_x       = mx_q;
	assign move_y       = my_q;
	assign move_wheel   = mw_q;
	assign clipped      = oclip_q;
	assign last         = last_q;

endmodule

/* rtl/hfrb_ctrl.sv */
// Controller FSM: sequences capture, decode, chunk loads and output handshake.
// Depends on hfrb_pkg.
module hfrb_ctrl import hfrb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t dp_cmd,
	input  dp_sts_t dp_sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		dp_cmd    = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				dp_cmd.cap = in_valid;
				if (in_valid)
					state_d = ST_DEC;
			end
			ST_DEC: begin
				dp_cmd.dec = 1'b1;
				case (dp_sts.kind)
					RES_ONE:    state_d = ST_SEND;
					RES_MOTION: state_d = ST_CHUNK;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_CHUNK: begin
				dp_cmd.chunk = 1'b1;
				state_d      = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (dp_sts.last)
						state_d = ST_IDLE;
					else
						dp_cmd.chunk = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/hid_frame_to_report_bridge_core.sv */
// HID frame to report bridge, top level: controller plus datapath.
// Depends on hfrb_pkg, hfrb_ctrl, hfrb_dp.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | in_valid / in_stall (out)  | cmd frame_len op_code flag_bits arg_byte
//          |                            | delta_x delta_y wheel_in
//  out     | out_valid / out_stall (in) | action key_code press_mask release_mask
//          |                            | move_valid move_x move_y move_wheel
//          |                            | clipped last
//
// One frame at a time. Accept, then the decode state, then words leave one per
// cycle from the output register while out_stall is low; a mouse frame with
// motion passes the setup state ST_CHUNK before its first chunk. A mouse frame
// yields N chunks, N up to MAX_CHUNKS; the chunk splitter (one +-127 step per
// word) sets N.
// arst_n clears the state machine and the held-button state.
// in_stall is high from accept until the last word is taken (until decode for a
// rejected frame); out_stall holds the current word and freezes the splitter.
module hid_frame_to_report_bridge_core import hfrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [15:0]        frame_len,
	input  logic [7:0]         op_code,
	input  logic [7:0]         flag_bits,
	input  logic [7:0]         arg_byte,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [7:0]  wheel_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         action,
	output logic [7:0]         key_code,
	output logic [2:0]         press_mask,
	output logic [2:0]         release_mask,
	output logic               move_valid,
	output logic signed [7:0]  move_x,
	output logic signed [7:0]  move_y,
	output logic signed [7:0]  move_wheel,
	output logic               clipped,
	output logic               last
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequencer
	hfrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	// checks, button edges, motion chunks, output word
	hfrb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.dp_sts       (dp_sts),
		.cmd          (cmd),
		.frame_len    (frame_len),
		.op_code      (op_code),
		.flag_bits    (flag_bits),
		.arg_byte     (arg_byte),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.wheel_in     (wheel_in),
		.action       (action),
		.key_code     (key_code),
		.press_mask   (press_mask),
		.release_mask (release_mask),
		.move_valid   (move_valid),
		.move_x       (move_x),
		.move_y       (move_y),
		.move_wheel   (move_wheel),
		.clipped      (clipped),
		.last         (last)
	);

	// chunks never exceed +-127
	a_chunk_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_valid |-> (move_x != -8'sd128) && (move_y != -8'sd128))
		else $error("motion chunk out of range");

	// only mouse words carry motion
	a_move_mouse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ACT_MOUSE) |-> !move_valid)
		else $error("motion on non-mouse word");

	// one frame at a time: no accept while a word is pending
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while output pending");

	// button-only mouse update is a single word
	a_btn_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_MOUSE) && !move_valid |-> last)
		else $error("button-only update not last");

	// taken word that is not last is followed by another word
	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("chunk sequence broken");

endmodule

/* bench/hid_frame_to_report_bridge_core_tb.sv */
// Self-checking bench for hid_frame_to_report_bridge_core: directed and random link words,
// an in-bench predictor of the report stream, and random idling on both channels.
// Depends on hfrb_pkg and the bridge RTL only.
`timescale 1ns / 100ps

module hid_frame_to_report_bridge_core_tb import hfrb_pkg::*; ();

	// one link word as presented on the input channel
	typedef struct packed {
		logic        cmd;
		logic [15:0] frame_len;
		logic [7:0]  op_code;
		logic [7:0]  flag_bits;
		logic [7:0]  arg_byte;
		logic [15:0] delta_x;
		logic [15:0] delta_y;
		logic [7:0]  wheel_in;
	} hid_frame_t;

	// one HID report word as seen on the output channel
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] key_code;
		logic [2:0] press_mask;
		logic [2:0] release_mask;
		logic       move_valid;
		logic [7:0] move_x;
		logic [7:0] move_y;
		logic [7:0] move_wheel;
		logic       clipped;
		logic       last;
	} hid_report_t;

	// motion budget per axis, clamped the same way the block clamps it
	localparam int CHUNK_BUDGET = (MAX_CHUNKS < 1) ? 1 : ((MAX_CHUNKS > 64) ? 64 : MAX_CHUNKS);
	localparam int STEP_LIM     = 127;
	localparam int AXIS_LIM     = CHUNK_BUDGET * STEP_LIM;
	localparam int CHUNK_CAP    = 64;
	localparam int WORD_TARGET  = 270;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = 1'b0;
	logic [15:0]        frame_len = '0;
	logic [7:0]         op_code = '0;
	logic [7:0]         flag_bits = '0;
	logic [7:0]         arg_byte = '0;
	logic signed [15:0] delta_x = '0;
	logic signed [15:0] delta_y = '0;
	logic signed [7:0]  wheel_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         action;
	logic [7:0]         key_code;
	logic [2:0]         press_mask;
	logic [2:0]         release_mask;
	logic               move_valid;
	logic signed [7:0]  move_x;
	logic signed [7:0]  move_y;
	logic signed [7:0]  move_wheel;
	logic               clipped;
	logic               last;

	hid_frame_to_report_bridge_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .frame_len(frame_len), .op_code(op_code), .flag_bits(flag_bits),
		.arg_byte(arg_byte), .delta_x(delta_x), .delta_y(delta_y), .wheel_in(wheel_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .key_code(key_code), .press_mask(press_mask),
		.release_mask(release_mask), .move_valid(move_valid), .move_x(move_x),
		.move_y(move_y), .move_wheel(move_wheel), .clipped(clipped), .last(last)
	);

	hid_frame_t  link_words_q[$];   // words still to be sent
	hid_report_t report_q[$];       // reports predicted, not yet seen
	logic [2:0]  held_btns = '0;    // predictor copy of the held-button state

	int words_total = 0;
	int words_sent = 0;
	int words_taken = 0;
	int reports_seen = 0;
	int chunks_seen = 0;
	int clipped_seen = 0;
	int mismatches = 0;
	int in_gap = 0;
	int in_calm = 0;
	int out_hold = 0;
	int out_calm = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop: far beyond 64 chunks per word, each waiting out the longest stall
	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// idle length: mostly zero or short, now and then long, with calm stretches of no idling
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_to(int v, int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic hid_frame_t frame_of(logic c, logic [15:0] len, logic [7:0] op,
			logic [7:0] flags, logic [7:0] arg, int dx, int dy, int w);
		hid_frame_t f;
		f.cmd       = c;
		f.frame_len = len;
		f.op_code   = op;
		f.flag_bits = flags;
		f.arg_byte  = arg;
		f.delta_x   = 16'(dx);
		f.delta_y   = 16'(dy);
		f.wheel_in  = 8'(w);
		return f;
	endfunction

	// Expected reports for one accepted word, appended to report_q.
	// Rejected frames add nothing; held_btns tracks the block's button state.
	function automatic void predict_reports(hid_frame_t f);
		hid_report_t r;
		logic [2:0]  btn, prs, rel;
		logic        clip;
		int          x, y, w, sx, sy, n;
		r = '0;
		if (f.cmd == CMD_LOST) begin
			held_btns = '0;
			r.action = ACT_REL_ALL;
			r.last = 1'b1;
			report_q.push_back(r);
			return;
		end
		// short frame or sequence flag clear: dropped
		if (f.frame_len < LEN_MIN || !f.flag_bits[0])
			return;
		case (f.op_code)
			OP_REL_ALL: begin
				if (f.frame_len != LEN_REL)
					return;
				held_btns = '0;
				r.action = ACT_REL_ALL;
				r.last = 1'b1;
				report_q.push_back(r);
			end
			OP_KEY_PRESS, OP_KEY_LIFT: begin
				// usage must be 1..0xA4 or a modifier 0xE0..0xE7
				if (f.frame_len != LEN_KEY)
					return;
				if (!((f.arg_byte >= MOD_LO && f.arg_byte <= MOD_HI) ||
						(f.arg_byte != 8'h00 && f.arg_byte < USAGE_END)))
					return;
				r.action = (f.op_code == OP_KEY_PRESS) ? ACT_PRESS : ACT_RELEASE;
				r.key_code = f.arg_byte;
				r.last = 1'b1;
				report_q.push_back(r);
			end
			OP_POINTER: begin
				if (f.frame_len != LEN_MOUSE)
					return;
				btn = f.arg_byte[2:0];
				prs = btn & ~held_btns;
				rel = held_btns & ~btn;
				held_btns = btn;
				x = int'($signed(f.delta_x));
				y = int'($signed(f.delta_y));
				w = int'($signed(f.wheel_in));
				if (x == 0 && y == 0 && w == 0) begin
					// buttons only, or nothing at all
					if (prs == '0 && rel == '0)
						return;
					r.action = ACT_MOUSE;
					r.press_mask = prs;
					r.release_mask = rel;
					r.last = 1'b1;
					report_q.push_back(r);
					return;
				end
				clip = (x > AXIS_LIM || x < -AXIS_LIM || y > AXIS_LIM || y < -AXIS_LIM);
				x = clamp_to(x, AXIS_LIM);
				y = clamp_to(y, AXIS_LIM);
				n = 0;
				do begin
					sx = clamp_to(x, STEP_LIM);
					sy = clamp_to(y, STEP_LIM);
					r = '0;
					r.action = ACT_MOUSE;
					if (n == 0) begin
						// edges and wheel ride on the first chunk only
						r.press_mask = prs;
						r.release_mask = rel;
						r.move_wheel = 8'(w);
					end
					r.move_valid = 1'b1;
					r.move_x = 8'(sx);
					r.move_y = 8'(sy);
					r.clipped = clip;
					x -= sx;
					y -= sy;
					n++;
					r.last = !((x != 0 || y != 0) && n < CHUNK_CAP);
					report_q.push_back(r);
				end while (!r.last);
			end
			default: ;
		endcase
	endfunction

	// random word: mostly well-formed frames with random content, the rest noise
	function automatic hid_frame_t random_frame(output bit noise);
		hid_frame_t f;
		int         r, m, dx, dy, w;
		logic [7:0] flags;
		flags = {7'($urandom), 1'b1};
		noise = 1'b0;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			f = frame_of(CMD_LOST, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				$urandom, $urandom, $urandom);
		end else if (r < 12) begin
			f = frame_of(CMD_FRAME, LEN_REL, OP_REL_ALL, flags, 8'($urandom), 0, 0, 0);
		end else if (r < 40) begin
			m = $urandom_range(0, 9);
			f = frame_of(CMD_FRAME, LEN_KEY,
				($urandom_range(0, 1) != 0) ? OP_KEY_PRESS : OP_KEY_LIFT,
				flags, (m < 6) ? 8'($urandom_range(1, 8'hA4)) :
				(m < 8) ? 8'($urandom_range(MOD_LO, MOD_HI)) : 8'($urandom), 0, 0, 0);
		end else if (r < 85) begin
			// most motion is small; a few reach past the chunk budget
			m = $urandom_range(0, 99);
			if (m < 15) begin
				dx = 0;
				dy = 0;
			end else if (m < 80) begin
				dx = $urandom_range(0, 600) - 300;
				dy = $urandom_range(0, 600) - 300;
			end else if (m < 95) begin
				dx = $urandom_range(0, 16600) - 8300;
				dy = $urandom_range(0, 16600) - 8300;
			end else begin
				dx = $urandom;
				dy = $urandom;
			end
			w = ($urandom_range(0, 1) != 0) ? 0 : $urandom;
			f = frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, flags, 8'($urandom), dx, dy, w);
		end else begin
			noise = 1'b1;
			f = frame_of(CMD_FRAME,
				($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 12)) : 16'($urandom),
				($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 6)) : 8'($urandom),
				8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
		end
		return f;
	endfunction

	task automatic check_field(string name, logic [7:0] expv, logic [7:0] actv);
		if (expv != actv) begin
			$display("%0t: report %0d %s expected 0x%0h actual 0x%0h",
				$time, reports_seen, name, expv, actv);
			mismatches++;
		end
	endtask

	// Input driver: changes only at the falling edge. A shown word holds until it is
	// taken; after that a random gap may follow before the next one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && words_taken != words_sent) begin
				// still waiting for the accept
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (link_words_q.size() > 0) begin
				hid_frame_t f;
				f = link_words_q.pop_front();
				cmd       <= f.cmd;
				frame_len <= f.frame_len;
				op_code   <= f.op_code;
				flag_bits <= f.flag_bits;
				arg_byte  <= f.arg_byte;
				delta_x   <= f.delta_x;
				delta_y   <= f.delta_y;
				wheel_in  <= f.wheel_in;
				in_valid  <= 1'b1;
				words_sent++;
				in_gap = idle_len(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure: stall bursts of random length between free cycles.
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
			out_hold = idle_len(out_calm);
		end
	end

	// Monitor: accepts on the input side feed the predictor; every accepted report is
	// checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_reports({cmd, frame_len, op_code, flag_bits, arg_byte,
					delta_x, delta_y, wheel_in});
				words_taken++;
			end
			if (out_valid && !out_stall) begin
				hid_report_t want;
				if (report_q.size() == 0) begin
					$display("%0t: unexpected report action %0d key 0x%0h x %0d y %0d",
						$time, action, key_code, move_x, move_y);
					mismatches++;
				end else begin
					want = report_q.pop_front();
					check_field("action", want.action, action);
					check_field("key_code", want.key_code, key_code);
					check_field("press_mask", want.press_mask, press_mask);
					check_field("release_mask", want.release_mask, release_mask);
					check_field("move_valid", want.move_valid, move_valid);
					check_field("move_x", want.move_x, move_x);
					check_field("move_y", want.move_y, move_y);
					check_field("move_wheel", want.move_wheel, move_wheel);
					check_field("clipped", want.clipped, clipped);
					check_field("last", want.last, last);
				end
				reports_seen++;
				if (move_valid)
					chunks_seen++;
				if (clipped)
					clipped_seen++;
			end
		end
	end

	initial begin
		hid_frame_t f;
		bit         noise;
		int         noise_words;

		// directed part
		// mouse with no change right after reset: dropped
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'h00, 0, 0, 0));
		// link lost, other fields all ones
		link_words_q.push_back(frame_of(CMD_LOST, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, -1, -1, -1));
		// key usage edges, legal and not
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_PRESS, 8'hFF, 8'h01, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_PRESS, 8'h01, 8'hA4, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_LIFT, 8'h01, 8'hE0, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_LIFT, 8'h01, 8'hE7, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_PRESS, 8'h01, 8'h00, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_PRESS, 8'h01, 8'hA5, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_LIFT, 8'h01, 8'hDF, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_LIFT, 8'h01, 8'hE8, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_PRESS, 8'h01, 8'hFF, 0, 0, 0));
		// release all: exact length, then wrong length
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_REL, OP_REL_ALL, 8'h01, 8'h00, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_REL_ALL, 8'h01, 8'h00, 0, 0, 0));
		// short frames, flag clear, unknown ops, an oversized length
		link_words_q.push_back(frame_of(CMD_FRAME, 16'd3, OP_REL_ALL, 8'h01, 8'h00, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, 16'd0, OP_KEY_PRESS, 8'h01, 8'h04, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_KEY, OP_KEY_PRESS, 8'hFE, 8'h04, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_REL, 8'h00, 8'h01, 8'h00, 0, 0, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, 8'h05, 8'h01, 8'h01, 5, 5, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, 16'hFFFF, OP_POINTER, 8'h01, 8'h01, 5, 5, 0));
		// buttons only: upper arg bits ignored
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'hFF, 0, 0, 0));
		// extreme motion: saturated, full chunk budget, wheel at minimum
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'h05,
			32767, -32768, -128));
		// exactly at the budget, then one past it
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'h02,
			AXIS_LIM, -AXIS_LIM, 0));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'h02,
			-AXIS_LIM - 1, 1, 0));
		// wheel only, then release all buttons with a tiny move
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'h02,
			0, 0, 127));
		link_words_q.push_back(frame_of(CMD_FRAME, LEN_MOUSE, OP_POINTER, 8'h01, 8'h00,
			1, 0, 0));

		// random part tops the queue up to the word target
		noise_words = 0;
		while (link_words_q.size() < WORD_TARGET) begin
			f = random_frame(noise);
			link_words_q.push_back(f);
			if (noise)
				noise_words++;
		end
		words_total = link_words_q.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_taken < words_total || report_q.size() != 0)
			@(posedge clk);
		// settle time: a late extra report would still show up here
		repeat (200) @(posedge clk);

		$display("Run covered %0d link words (%0d malformed) and %0d reports (%0d motion chunks, %0d clipped).",
			words_taken, noise_words, reports_seen, chunks_seen, clipped_seen);
		$display("Field mismatches or stray reports: %0d.", mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
